@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the k-best heap block.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of clk, held off while rst_n is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression is never true on the rising edge of clk.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

@@ hdl/bmhkb_pkg.sv @@
// Package for the k-best heap block: sizes, entry layout and request codes.
// Depends on nothing; used by the top level bounded_max_heap_k_best.
package bmhkb_pkg;

	localparam int CAPACITY     = 64;
	localparam int DIST_BITS    = 32;
	localparam int PAYLOAD_BITS = 16;

	// Heap address, entry count and child index widths
	localparam int ADDR_W  = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int CHILD_W = ADDR_W + 2;
	localparam int ENTRY_W = DIST_BITS + PAYLOAD_BITS;

	// Capacity register field width, fixed by the register definition
	localparam int CAP_W = 7;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_POP    = 2'd1,
		REQ_PEEK   = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	typedef struct packed {
		logic [DIST_BITS-1:0]    key;
		logic [PAYLOAD_BITS-1:0] pay;
	} entry_t;

endpackage

@@ hdl/bmhkb_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
// Depends on nothing; holds the heap entries of the k-best heap block.
module bmhkb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

@@ hdl/bounded_max_heap_k_best.sv @@
// Top level of the k-best heap block: sequencer, capacity register, APB port.
// Depends on bmhkb_pkg, bmhkb_ram and assert_macros.svh.
//
// Usage:
//   Keeps the k smallest distances seen, each with a 16-bit tag, in a binary
//   max-heap in one RAM (two read ports, one write port, registered read).
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. req_type selects insert, pop largest, peek largest or no-op.
//   Result channel: done is high for exactly one cycle with out_distance,
//   out_payload, empty_res, accepted and count valid; the receiver cannot
//   stall, so the result must be captured in that cycle.
//   A no-op, or a pop or peek on an empty heap, is answered from idle; other
//   requests read the root and last entry first, where a peek ends. A pop
//   sinks the last entry, an insert sifts up, and an evicting insert sinks
//   first. One transaction at a time: a sift level is one RAM read, compare
//   and write back, and heap depth (log2 of capacity) sets the worst case.
//   Configuration: APB register 0 (byte address 0) is capacity, 7 bits; write
//   it only while busy is low and no result is pending.
//   Reset: count clears to zero and capacity returns to 64; the RAM is not
//   cleared since only entries below the count are ever used.
module bounded_max_heap_k_best (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bmhkb_pkg::PADDR_W-1:0]     paddr,
	input  logic [bmhkb_pkg::PDATA_W-1:0]     pwdata,
	output logic [bmhkb_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready,
	// command channel
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        req_type,
	input  logic [bmhkb_pkg::DIST_BITS-1:0]   distance,
	input  logic [bmhkb_pkg::PAYLOAD_BITS-1:0] payload,
	input  logic                              has_payload,
	// result channel
	output logic                              done,
	output logic [bmhkb_pkg::DIST_BITS-1:0]   out_distance,
	output logic [bmhkb_pkg::PAYLOAD_BITS-1:0] out_payload,
	output logic                              empty_res,
	output logic                              accepted,
	output logic [bmhkb_pkg::CNT_W-1:0]       count
);

	`include "assert_macros.svh"

	localparam int ADDR_W  = bmhkb_pkg::ADDR_W;
	localparam int CNT_W   = bmhkb_pkg::CNT_W;
	localparam int CHILD_W = bmhkb_pkg::CHILD_W;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_ROOT = 6'b000010,
		ST_INS  = 6'b000100,
		ST_UP   = 6'b001000,
		ST_DN   = 6'b010000,
		ST_WR   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// Transaction registers
	bmhkb_pkg::req_t   req_q, req_d;
	bmhkb_pkg::entry_t new_q, new_d;    // entry an insert will place
	bmhkb_pkg::entry_t item_q, item_d;  // entry being sifted
	logic [ADDR_W-1:0] pos_q, pos_d;    // hole the sifted entry sits in
	logic [CNT_W-1:0]  count_q, count_d;
	logic              evict_q, evict_d; // insert pending after root eviction

	// Result registers
	logic                                done_q, done_d;
	logic [bmhkb_pkg::DIST_BITS-1:0]     out_dist_q, out_dist_d;
	logic [bmhkb_pkg::PAYLOAD_BITS-1:0]  out_pay_q, out_pay_d;
	logic                                empty_q, empty_d;
	logic                                accepted_q, accepted_d;

	logic [bmhkb_pkg::CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0]            cap_eff;

	// RAM ports
	logic                          mem_we;
	logic [ADDR_W-1:0]             mem_waddr, mem_raddr_a, mem_raddr_b;
	bmhkb_pkg::entry_t             mem_wdata, rd_a, rd_b;
	logic [bmhkb_pkg::ENTRY_W-1:0] rdata_a, rdata_b;

	// Address arithmetic
	logic [CNT_W-1:0]   cnt_m1;
	logic [ADDR_W-1:0]  par_pos, grand_pos, ins_par;
	logic [CHILD_W-1:0] child_l, child_r, next_l, next_r, count_ext;
	logic               sel_r;
	bmhkb_pkg::entry_t  c_ent;
	logic [ADDR_W-1:0]  c_pos;
	logic               go_down, sift_end;

	bmhkb_ram #(
		.WIDTH(bmhkb_pkg::ENTRY_W),
		.DEPTH(bmhkb_pkg::CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign rd_a = bmhkb_pkg::entry_t'(rdata_a);
	assign rd_b = bmhkb_pkg::entry_t'(rdata_b);

	// ---------------------------------------------------------------
	// APB register: capacity, clamped to the RAM depth when used
	// ---------------------------------------------------------------
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[2:2] == bmhkb_pkg::REG_CAPACITY) begin
			prdata = bmhkb_pkg::PDATA_W'(capacity_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= bmhkb_pkg::CAP_W'(bmhkb_pkg::CAPACITY);
		end else if (psel && penable && pwrite && pready &&
				(paddr[2:2] == bmhkb_pkg::REG_CAPACITY)) begin
			capacity_q <= pwdata[bmhkb_pkg::CAP_W-1:0];
		end
	end

	assign cap_eff = (CNT_W'(capacity_q) > CNT_W'(bmhkb_pkg::CAPACITY)) ?
		CNT_W'(bmhkb_pkg::CAPACITY) : CNT_W'(capacity_q);

	// ---------------------------------------------------------------
	// Heap index arithmetic
	// ---------------------------------------------------------------
	assign cnt_m1    = count_q - CNT_W'(1);
	assign par_pos   = (pos_q - ADDR_W'(1)) >> 1;
	assign grand_pos = (par_pos - ADDR_W'(1)) >> 1;
	assign ins_par   = ADDR_W'((count_q - CNT_W'(1)) >> 1);
	assign count_ext = CHILD_W'(count_q);

	// Children of the current hole; the larger wins, left on a tie
	assign child_l = {1'b0, pos_q, 1'b1};
	assign child_r = child_l + CHILD_W'(1);
	assign sel_r   = (child_r < count_ext) && (rd_b.key > rd_a.key);
	assign c_ent   = sel_r ? rd_b : rd_a;
	assign c_pos   = sel_r ? child_r[ADDR_W-1:0] : child_l[ADDR_W-1:0];
	assign next_l  = {1'b0, c_pos, 1'b1};
	assign next_r  = next_l + CHILD_W'(1);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_comb begin
		state_d    = state_q;
		req_d      = req_q;
		new_d      = new_q;
		item_d     = item_q;
		pos_d      = pos_q;
		count_d    = count_q;
		evict_d    = evict_q;
		done_d     = 1'b0;
		out_dist_d = out_dist_q;
		out_pay_d  = out_pay_q;
		empty_d    = empty_q;
		accepted_d = accepted_q;
		mem_we     = 1'b0;
		mem_waddr  = pos_q;
		mem_wdata  = item_q;
		mem_raddr_a = '0;
		mem_raddr_b = '0;
		go_down    = 1'b0;
		sift_end   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					req_d      = bmhkb_pkg::req_t'(req_type);
					new_d.key  = distance;
					new_d.pay  = has_payload ? payload : '0;
					out_dist_d = '0;
					out_pay_d  = '0;
					empty_d    = 1'b0;
					accepted_d = 1'b0;
					evict_d    = 1'b0;
					priority if (bmhkb_pkg::req_t'(req_type) == bmhkb_pkg::REQ_NOP) begin
						done_d = 1'b1;
					end else if ((bmhkb_pkg::req_t'(req_type) != bmhkb_pkg::REQ_INSERT) &&
							(count_q == '0)) begin
						// pop or peek on an empty heap: answer at once
						empty_d = 1'b1;
						done_d  = 1'b1;
					end else begin
						// fetch root and last entry
						mem_raddr_a = '0;
						mem_raddr_b = cnt_m1[ADDR_W-1:0];
						state_d     = ST_ROOT;
					end
				end
			end

			ST_ROOT: begin
				unique case (req_q)
					bmhkb_pkg::REQ_PEEK: begin
						out_dist_d = rd_a.key;
						out_pay_d  = rd_a.pay;
						done_d     = 1'b1;
						state_d    = ST_IDLE;
					end
					bmhkb_pkg::REQ_POP: begin
						out_dist_d = rd_a.key;
						out_pay_d  = rd_a.pay;
						go_down    = 1'b1;
					end
					bmhkb_pkg::REQ_INSERT: begin
						priority if ((count_q == cap_eff) && (count_q != '0) &&
								(rd_a.key > new_q.key)) begin
							// full and the root is worse: evict it first
							evict_d = 1'b1;
							go_down = 1'b1;
						end else if (count_q < cap_eff) begin
							state_d = ST_INS;
						end else begin
							// discard: accepted stays low
							done_d  = 1'b1;
							state_d = ST_IDLE;
						end
					end
					default: begin
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end
				endcase
			end

			ST_INS: begin
				// open a hole at the end and sift the new entry up
				pos_d      = count_q[ADDR_W-1:0];
				count_d    = count_q + CNT_W'(1);
				item_d     = new_q;
				accepted_d = 1'b1;
				evict_d    = 1'b0;
				if (count_q == '0) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = new_q;
					done_d    = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					mem_raddr_a = ins_par;
					state_d     = ST_UP;
				end
			end

			ST_UP: begin
				// rd_a holds the parent of the hole
				mem_we = 1'b1;
				if (item_q.key > rd_a.key) begin
					mem_wdata = rd_a;
					pos_d     = par_pos;
					if (par_pos != '0) begin
						mem_raddr_a = grand_pos;
					end else begin
						state_d = ST_WR;
					end
				end else begin
					sift_end = 1'b1;
				end
			end

			ST_DN: begin
				// rd_a and rd_b hold the children of the hole
				mem_we = 1'b1;
				if (c_ent.key > item_q.key) begin
					mem_wdata = c_ent;
					pos_d     = c_pos;
					if (next_l < count_ext) begin
						mem_raddr_a = next_l[ADDR_W-1:0];
						mem_raddr_b = next_r[ADDR_W-1:0];
					end else begin
						state_d = ST_WR;
					end
				end else begin
					sift_end = 1'b1;
				end
			end

			ST_WR: begin
				mem_we   = 1'b1;
				sift_end = 1'b1;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Remove the root: the last entry sinks from the root position
		if (go_down) begin
			count_d = cnt_m1;
			item_d  = rd_b;
			pos_d   = '0;
			priority if (cnt_m1 > CNT_W'(1)) begin
				mem_raddr_a = ADDR_W'(1);
				mem_raddr_b = ADDR_W'(2);
				state_d     = ST_DN;
			end else if (cnt_m1 == CNT_W'(1)) begin
				state_d = ST_WR;
			end else if (evict_d) begin
				state_d = ST_INS;
			end else begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
		end

		// A sift has placed its entry: insert after an eviction, else finish
		if (sift_end) begin
			if (evict_q) begin
				state_d = ST_INS;
			end else begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			evict_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			evict_q <= evict_d;
			done_q  <= done_d;
		end
	end

	// Payload registers: no reset
	always_ff @(posedge clk) begin
		req_q      <= req_d;
		new_q      <= new_d;
		item_q     <= item_d;
		pos_q      <= pos_d;
		out_dist_q <= out_dist_d;
		out_pay_q  <= out_pay_d;
		empty_q    <= empty_d;
		accepted_q <= accepted_d;
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign out_distance = out_dist_q;
	assign out_payload  = out_pay_q;
	assign empty_res    = empty_q;
	assign accepted     = accepted_q;
	assign count        = count_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`ASSERT_CLK(a_count_bound, clk, arst_n, count_q <= CNT_W'(bmhkb_pkg::CAPACITY), "count above capacity")
	`ASSERT_NEVER(a_idle_no_write, clk, arst_n, (state_q == ST_IDLE) && mem_we, "RAM write while idle")
	`ASSERT_NEVER(a_up_at_root, clk, arst_n, (state_q == ST_UP) && (pos_q == '0), "sift-up with hole at root")
	`ASSERT_CLK(a_done_follows_work, clk, arst_n, done_q |-> $past(busy || start), "result without a transaction")

endmodule

@@ verif/bmhkb_heap_monitor.sv @@
// Monitor for the k-best heap block: predicts every result and compares it on the strobe.
// Depends on bmhkb_pkg; the test top instantiates it beside the block.
module bmhkb_heap_monitor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bmhkb_pkg::PADDR_W-1:0]      paddr,
	input  logic [bmhkb_pkg::PDATA_W-1:0]      pwdata,
	input  logic [bmhkb_pkg::PDATA_W-1:0]      prdata,
	input  logic                               pready,
	input  logic                               start,
	input  logic                               busy,
	input  logic [1:0]                         req_type,
	input  logic [bmhkb_pkg::DIST_BITS-1:0]    distance,
	input  logic [bmhkb_pkg::PAYLOAD_BITS-1:0] payload,
	input  logic                               has_payload,
	input  logic                               done,
	input  logic [bmhkb_pkg::DIST_BITS-1:0]    out_distance,
	input  logic [bmhkb_pkg::PAYLOAD_BITS-1:0] out_payload,
	input  logic                               empty_res,
	input  logic                               accepted,
	input  logic [bmhkb_pkg::CNT_W-1:0]        count,
	output int                                 mismatches,
	output int                                 pending
);
	import bmhkb_pkg::*;

	typedef struct packed {
		logic [DIST_BITS-1:0]    key;
		logic [PAYLOAD_BITS-1:0] pay;
		logic                    empty;
		logic                    acc;
		logic [CNT_W-1:0]        cnt;
	} outcome_t;

	logic [DIST_BITS-1:0]    key_mem [CAPACITY];
	logic [PAYLOAD_BITS-1:0] tag_mem [CAPACITY];
	int unsigned             held;
	logic [CAP_W-1:0]        cap_reg;
	outcome_t                owed_results [$];

	function automatic void flag(string msg);
		if (mismatches < 10) begin
			$display("%s", msg);
		end
		mismatches++;
	endfunction

	// Move a node toward the root while it is strictly larger than its parent.
	function automatic void rise_from(int unsigned pos);
		logic [DIST_BITS-1:0]    k;
		logic [PAYLOAD_BITS-1:0] t;
		int unsigned             par;
		k = key_mem[pos];
		t = tag_mem[pos];
		while (pos > 0) begin
			par = (pos - 1) / 2;
			if (k > key_mem[par]) begin
				key_mem[pos] = key_mem[par];
				tag_mem[pos] = tag_mem[par];
				pos = par;
			end else begin
				break;
			end
		end
		key_mem[pos] = k;
		tag_mem[pos] = t;
	endfunction

	// Sink a node: pick the larger child (left on a tie), swap only while strictly larger.
	function automatic void sink_from(int unsigned pos);
		logic [DIST_BITS-1:0]    k;
		logic [PAYLOAD_BITS-1:0] t;
		int unsigned             lc;
		int unsigned             rc;
		int unsigned             pick;
		k = key_mem[pos];
		t = tag_mem[pos];
		while (pos * 2 + 1 < held) begin
			lc = pos * 2 + 1;
			rc = lc + 1;
			pick = lc;
			if (rc < held && key_mem[rc] > key_mem[lc]) begin
				pick = rc;
			end
			if (key_mem[pick] > k) begin
				key_mem[pos] = key_mem[pick];
				tag_mem[pos] = tag_mem[pick];
				pos = pick;
			end else begin
				break;
			end
		end
		key_mem[pos] = k;
		tag_mem[pos] = t;
	endfunction

	function automatic void take_top(output logic [DIST_BITS-1:0] k,
			output logic [PAYLOAD_BITS-1:0] t);
		int unsigned last;
		last = held - 1;
		k = key_mem[0];
		t = tag_mem[0];
		held = last;
		if (last > 0) begin
			key_mem[0] = key_mem[last];
			tag_mem[0] = tag_mem[last];
			sink_from(0);
		end
	endfunction

	function automatic outcome_t apply_to_heap(req_t rq, logic [DIST_BITS-1:0] d,
			logic [PAYLOAD_BITS-1:0] p, logic hp);
		outcome_t                o;
		int unsigned             limit;
		logic [DIST_BITS-1:0]    k;
		logic [PAYLOAD_BITS-1:0] t;
		o = '0;
		limit = (cap_reg > CAPACITY) ? CAPACITY : cap_reg;
		case (rq)
			REQ_INSERT: begin
				// evict the root only when full and the root is strictly larger
				if (held == limit && held > 0 && key_mem[0] > d) begin
					take_top(k, t);
				end
				if (held < limit) begin
					key_mem[held] = d;
					tag_mem[held] = hp ? p : '0;
					held++;
					rise_from(held - 1);
					o.acc = 1'b1;
				end
			end
			REQ_POP, REQ_PEEK: begin
				if (held == 0) begin
					o.empty = 1'b1;
				end else if (rq == REQ_POP) begin
					take_top(k, t);
					o.key = k;
					o.pay = t;
				end else begin
					o.key = key_mem[0];
					o.pay = tag_mem[0];
				end
			end
			default: ;
		endcase
		o.cnt = CNT_W'(held);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			held = 0;
			cap_reg = CAP_W'(CAPACITY);
			owed_results.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			// compare the strobed result before taking a new request in the same edge
			if (done) begin
				got = '{out_distance, out_payload, empty_res, accepted, count};
				if (owed_results.size() == 0) begin
					flag($sformatf("unexpected result: dist=%h pay=%h empty=%b acc=%b count=%0d",
						got.key, got.pay, got.empty, got.acc, got.cnt));
				end else begin
					want = owed_results.pop_front();
					if (got.key !== want.key || got.pay !== want.pay || got.empty !== want.empty
							|| got.acc !== want.acc || got.cnt !== want.cnt) begin
						flag($sformatf({"result mismatch: expected dist=%h pay=%h empty=%b acc=%b",
							" count=%0d, got dist=%h pay=%h empty=%b acc=%b count=%0d"},
							want.key, want.pay, want.empty, want.acc, want.cnt,
							got.key, got.pay, got.empty, got.acc, got.cnt));
					end
				end
			end
			if (start && !busy) begin
				owed_results.push_back(apply_to_heap(req_t'(req_type), distance, payload,
					has_payload));
			end
			if (psel && penable && pready && paddr == {REG_CAPACITY, 2'b00}) begin
				if (pwrite) begin
					cap_reg = pwdata[CAP_W-1:0];
				end else if (prdata !== PDATA_W'(cap_reg)) begin
					flag($sformatf("capacity read mismatch: expected %h, got %h",
						PDATA_W'(cap_reg), prdata));
				end
			end
			pending = owed_results.size();
		end
	end

endmodule

@@ verif/bounded_max_heap_k_best_test.sv @@
// Test top for the k-best heap block: clock, reset, command and APB stimulus, verdict.
// Depends on bmhkb_pkg, bounded_max_heap_k_best and bmhkb_heap_monitor.
module bounded_max_heap_k_best_test;
	import bmhkb_pkg::*;

	// request mixes: fill the heap, drain it, or keep it roughly level
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [PADDR_W-1:0]      paddr;
	logic [PDATA_W-1:0]      pwdata;
	logic [PDATA_W-1:0]      prdata;
	logic                    pready;
	logic                    start;
	logic                    busy;
	logic [1:0]              req_type;
	logic [DIST_BITS-1:0]    distance;
	logic [PAYLOAD_BITS-1:0] payload;
	logic                    has_payload;
	logic                    done;
	logic [DIST_BITS-1:0]    out_distance;
	logic [PAYLOAD_BITS-1:0] out_payload;
	logic                    empty_res;
	logic                    accepted;
	logic [CNT_W-1:0]        count;
	int                      mismatches;
	int                      pending;
	bit                      allow_gaps;

	bounded_max_heap_k_best dut (.*);

	bmhkb_heap_monitor heap_check (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Hard stop: far beyond the slowest legal run (max gap plus evicting insert per item).
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Issue one command transaction; call at a falling edge, returns at the falling
	// edge after acceptance with start still high so back-to-back items stay seamless.
	task automatic issue(input req_t rq, input logic [DIST_BITS-1:0] d,
			input logic [PAYLOAD_BITS-1:0] p, input logic hp);
		int gap;
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		req_type = rq;
		distance = d;
		payload = p;
		has_payload = hp;
		// hold the request until a rising edge sees busy low
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Write the capacity register once the block is idle, then read it back.
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		logic [PDATA_W-1:0] word;
		start = 1'b0;
		while (pending != 0 || busy) @(negedge clk);
		// random upper bits: only the low field is kept
		word = $urandom;
		word[CAP_W-1:0] = cap;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {REG_CAPACITY, 2'b00};
		pwdata = word;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Bias toward extremes and a narrow band so ties and equal-key discards show up.
	function automatic logic [DIST_BITS-1:0] pick_distance();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return DIST_BITS'($urandom_range(0, 15));
			5: return {{(DIST_BITS-4){1'b1}}, 4'($urandom_range(0, 15))};
			default: return DIST_BITS'($urandom);
		endcase
	endfunction

	// One phase: set the capacity, then run random requests. No-ops ride along but
	// do not count toward the phase length.
	task automatic run_phase(input logic [CAP_W-1:0] cap, input int n, input mix_t mix);
		int   taken;
		int   roll;
		int   ins_pct;
		int   pop_pct;
		req_t rq;
		write_capacity(cap);
		ins_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 30 : 50;
		pop_pct = (mix == MIX_FILL) ? 12 : (mix == MIX_DRAIN) ? 50 : 30;
		taken = 0;
		while (taken < n) begin
			roll = $urandom_range(0, 99);
			if (roll < ins_pct) begin
				rq = REQ_INSERT;
			end else if (roll < ins_pct + pop_pct) begin
				rq = REQ_POP;
			end else if (roll < ins_pct + pop_pct + 10) begin
				rq = REQ_PEEK;
			end else begin
				rq = REQ_NOP;
			end
			issue(rq, pick_distance(), PAYLOAD_BITS'($urandom), $urandom_range(0, 3) != 0);
			if (rq != REQ_NOP) begin
				taken++;
			end
		end
	endtask

	initial begin
		// drive every input to a known value before reset releases
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		req_type = REQ_NOP;
		distance = '0;
		payload = '0;
		has_payload = 1'b0;
		allow_gaps = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, capacity at its reset value: empty pop and peek, the no-op
		// request, extreme keys and payloads, missing payload, equal keys.
		issue(REQ_PEEK, '1, '1, 1'b1);
		issue(REQ_POP, '1, '1, 1'b1);
		issue(REQ_NOP, '1, '1, 1'b1);
		issue(REQ_INSERT, '1, 16'hFFFF, 1'b1);
		issue(REQ_INSERT, '0, 16'h1234, 1'b0);
		issue(REQ_INSERT, 32'd7, 16'h0007, 1'b1);
		issue(REQ_INSERT, 32'd7, 16'h0008, 1'b1);
		issue(REQ_PEEK, '0, '0, 1'b0);
		issue(REQ_POP, '0, '0, 1'b0);
		issue(REQ_POP, '0, '0, 1'b0);
		issue(REQ_POP, '0, '0, 1'b0);
		issue(REQ_POP, '0, '0, 1'b0);

		// Capacity one: eviction on a strictly smaller key, discard on equal or larger.
		write_capacity(7'd1);
		issue(REQ_INSERT, 32'd100, 16'hA5A5, 1'b1);
		issue(REQ_INSERT, 32'd50, 16'h5A5A, 1'b1);
		issue(REQ_INSERT, 32'd50, 16'h0F0F, 1'b1);
		issue(REQ_INSERT, 32'd60, 16'hF0F0, 1'b1);
		issue(REQ_PEEK, '0, '0, 1'b0);

		// Capacity zero: held entry sits above the limit, every insert is rejected.
		write_capacity(7'd0);
		issue(REQ_INSERT, 32'd1, 16'h0001, 1'b1);
		issue(REQ_POP, '0, '0, 1'b0);
		issue(REQ_INSERT, 32'd1, 16'h0001, 1'b1);

		// Random phases. The shrink after a full heap leaves the count above the limit;
		// capacity 127 saturates to the array size.
		run_phase(7'd64, 160, MIX_FILL);
		run_phase(7'd3, 70, MIX_DRAIN);
		run_phase(7'd1, 80, MIX_DRAIN);
		run_phase(7'd127, 150, MIX_FILL);
		run_phase(7'd0, 40, MIX_EVEN);
		run_phase(7'd16, 100, MIX_EVEN);
		run_phase(7'd2, 60, MIX_EVEN);
		run_phase(CAP_W'($urandom_range(1, 64)), 80, MIX_EVEN);
		// last stretch runs back to back
		allow_gaps = 1'b0;
		run_phase(7'd64, 120, MIX_FILL);

		// drain: wait for the last result, then give a stray strobe time to show
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (24) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
